// File: hw/rtl/stmg_pkg.sv
// Shared types and constants for the support triangle stability margin core.
// Holds status codes, queue depth, CORDIC angle table and port field widths.
// No dependencies.
package stmg_pkg;

  typedef enum logic [1:0] {
    ST_INSIDE  = 2'd0,
    ST_DEGEN   = 2'd1,
    ST_OUTSIDE = 2'd2
  } stat_t;

  localparam int LEG_W      = 2;
  localparam int QDEPTH     = 4;
  localparam int QLEVEL_W   = 3;
  localparam int CORDIC_N   = 24;
  localparam int DIV_N      = 16;
  localparam int DIST_W     = 16;
  localparam int OUT_DATA_W = 32;
  localparam int OUT_USER_W = 3;
  localparam int CORDIC_W   = 34;
  localparam logic [31:0] CORDIC_GAIN = 32'd652032874;
  localparam logic [DIST_W-1:0] DIST_SAT = '1;

  localparam logic [31:0] ATAN_TURN [CORDIC_N] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667330,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

endpackage

// File: hw/rtl/support_triangle_stability_margin_core.sv
// Top level of the support triangle stability margin core.
// Instantiates stmg_front, stmg_fifo and stmg_back; uses stmg_pkg.

// Takes one stance item per clock while in_tready is high and returns one
// result per item, in order. Two front stages select feet and form cross
// products (the first loaded at the transfer edge); the item then passes
// through the queue and the back stages, whose depth is set by the 24-step
// CORDIC for the heading vector, the ray products and the 16-step restoring
// dividers, all fully pipelined.
// The whole back pipeline stalls while a result waits on out_tready; the
// four-entry queue absorbs items already in the front stages.
module support_triangle_stability_margin_core import stmg_pkg::*; #(
  parameter int COORD_WIDTH = 16,
  parameter int ANGLE_WIDTH = 16,
  localparam int IN_DW = ((8 * COORD_WIDTH + ANGLE_WIDTH + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // foot1_x, foot1_y, foot2_x, foot2_y, foot3_x, foot3_y, foot4_x, foot4_y,
  // heading_angle, zero pad
  input  logic [IN_DW-1:0]      in_tdata,
  // lifted_leg
  input  logic [LEG_W-1:0]      in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // edge_margin, heading_distance
  output logic [OUT_DATA_W-1:0] out_tdata,
  // status, heading_hit
  output logic [OUT_USER_W-1:0] out_tuser
);

  localparam int CW = 2 * COORD_WIDTH + 1;
  localparam int FW = 6 * COORD_WIDTH + 3 * CW + 2 + ANGLE_WIDTH;

  logic                push, head_valid, pop;
  logic [FW-1:0]       push_data, head_data;
  logic [QLEVEL_W-1:0] level;

  stmg_front #(.W(COORD_WIDTH), .A(ANGLE_WIDTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .level     (level),
    .push      (push),
    .push_data (push_data)
  );

  stmg_fifo #(.WIDTH(FW), .DEPTH(QDEPTH)) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data),
    .level      (level)
  );

  stmg_back #(.W(COORD_WIDTH), .A(ANGLE_WIDTH)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

`ifndef SYNTHESIS
  a_quiet_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[1:0] != ST_INSIDE) |-> (out_tdata == '0) && !out_tuser[2])
    else $error("non-inside result carries margin or hit");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser[1:0] == ST_INSIDE) || (out_tuser[1:0] == ST_DEGEN) ||
                   (out_tuser[1:0] == ST_OUTSIDE))
    else $error("undefined status code");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (level < QLEVEL_W'(QDEPTH)) || pop)
    else $error("queue overflow");

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("pop from empty queue");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");
`endif

endmodule

// File: hw/rtl/stmg_fifo.sv
// Small register queue between the front and back pipelines.
// Generic width and depth; no package dependency.
module stmg_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int LW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data,
  output logic [LW-1:0]    level
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic [LW-1:0]    level_r, level_nxt;

  always_comb begin
    wp_nxt    = wp_r;
    rp_nxt    = rp_r;
    level_nxt = level_r;
    if (push) begin
      wp_nxt = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1);
    end
    if (pop) begin
      rp_nxt = (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + AW'(1);
    end
    if (push && !pop) begin
      level_nxt = level_r + LW'(1);
    end else if (pop && !push) begin
      level_nxt = level_r - LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      level_r <= '0;
    end else begin
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      level_r <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  assign head_valid = (level_r != '0);
  assign head_data  = mem_r[rp_r];
  assign level      = level_r;

endmodule

// File: hw/rtl/stmg_front.sv
// Front pipeline: accepts stance items, picks the three support feet,
// forms the edge cross products and classifies the triangle. Uses stmg_pkg.
module stmg_front import stmg_pkg::*; #(
  parameter int W = 16,
  parameter int A = 16,
  localparam int IN_DW = ((8 * W + A + 7) / 8) * 8,
  localparam int CW = 2 * W + 1,
  localparam int FW = 6 * W + 3 * CW + 2 + A
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [IN_DW-1:0]    in_tdata,
  input  logic [LEG_W-1:0]    in_tuser,
  input  logic [QLEVEL_W-1:0] level,
  output logic                push,
  output logic [FW-1:0]       push_data
);

  logic signed [W-1:0]   fx [4];
  logic signed [W-1:0]   fy [4];
  logic [1:0]            sel [3];
  logic                  accept;
  logic [QLEVEL_W:0]     occ;

  logic                  v1_r, v2_r;
  logic signed [W-1:0]   px1_r [3];
  logic signed [W-1:0]   py1_r [3];
  logic [A-1:0]          ang1_r, ang2_r;
  logic signed [2*W-1:0] pa_r [3];
  logic signed [2*W-1:0] pb_r [3];
  logic signed [W-1:0]   px2_r [3];
  logic signed [W-1:0]   py2_r [3];

  logic signed [CW-1:0]  c [3];
  logic signed [CW+1:0]  d;
  stat_t                 status;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      fx[k] = in_tdata[2 * k * W +: W];
      fy[k] = in_tdata[(2 * k + 1) * W +: W];
    end
    for (int j = 0; j < 3; j++) begin
      sel[j] = (2'(j) < in_tuser) ? 2'(j) : 2'(j + 1);
    end
  end

  assign occ       = {1'b0, level} + (QLEVEL_W + 1)'(v1_r) + (QLEVEL_W + 1)'(v2_r);
  assign in_tready = (occ < (QLEVEL_W + 1)'(QDEPTH));
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      px1_r[j] <= fx[sel[j]];
      py1_r[j] <= fy[sel[j]];
      pa_r[j]  <= px1_r[j] * py1_r[(j + 1) % 3];
      pb_r[j]  <= py1_r[j] * px1_r[(j + 1) % 3];
    end
    ang1_r <= in_tdata[8 * W +: A];
    ang2_r <= ang1_r;
    px2_r  <= px1_r;
    py2_r  <= py1_r;
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      c[j] = CW'(pa_r[j]) - CW'(pb_r[j]);
    end
    d = (CW + 2)'(c[0]) + (CW + 2)'(c[1]) + (CW + 2)'(c[2]);
    priority if (d == '0) begin
      status = ST_DEGEN;
    end else if ((c[0] >= 0 && c[1] >= 0 && c[2] >= 0) ||
                 (c[0] <= 0 && c[1] <= 0 && c[2] <= 0)) begin
      status = ST_INSIDE;
    end else begin
      status = ST_OUTSIDE;
    end
  end

  assign push      = v2_r;
  assign push_data = {ang2_r, status, c[2], c[1], c[0],
                      py2_r[2], py2_r[1], py2_r[0], px2_r[2], px2_r[1], px2_r[0]};

endmodule

// File: hw/rtl/stmg_back.sv
// Back pipeline: edge distances, heading CORDIC, ray tests, divisions and
// first-hit selection, ending in the output register. Uses stmg_pkg.
module stmg_back import stmg_pkg::*; #(
  parameter int W = 16,
  parameter int A = 16,
  localparam int CW = 2 * W + 1,
  localparam int FW = 6 * W + 3 * CW + 2 + A
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  head_valid,
  input  logic [FW-1:0]         head_data,
  output logic                  pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [OUT_USER_W-1:0] out_tuser
);

  localparam int EW  = (4 * W + 3 > 2 * W + 36) ? 4 * W + 3 : 2 * W + 36;
  localparam int LNW = 2 * W + 3;
  localparam int RW  = W + 20;
  localparam int NW  = ((CW > RW) ? CW : RW) + 1;
  localparam int CX  = CORDIC_W;
  localparam int S_ROUND = CORDIC_N + 1;
  localparam int S_PROD  = CORDIC_N + 2;
  localparam int S_NORM  = CORDIC_N + 3;
  localparam int S_DIVE  = S_NORM + DIV_N;
  localparam int S_OUT   = S_DIVE + 1;
  localparam int S_MG    = DIV_N + 1;
  localparam logic signed [CX-1:0] UNIT  = CX'(65536);
  localparam logic signed [CX-1:0] NUNIT = -CX'(65536);
  localparam logic signed [CX-1:0] RHALF = CX'(8192);

  logic adv;
  logic vld_r [0:S_OUT];

  logic signed [W-1:0]  g_px_r [0:S_ROUND][3];
  logic signed [W-1:0]  g_py_r [0:S_ROUND][3];
  logic signed [W:0]    g_sx_r [0:S_ROUND][3];
  logic signed [W:0]    g_sy_r [0:S_ROUND][3];
  logic signed [CW-1:0] g_c_r  [0:S_PROD][3];
  logic [1:0]           g_st_r [0:S_DIVE];
  logic [1:0]           g_q_r  [0:CORDIC_N];

  logic [4*W-1:0]    ed_c2_r  [0:DIV_N-1][3];
  logic [LNW-1:0]    ed_len_r [0:DIV_N-1][3];
  logic [EW-1:0]     ed_mm_r  [1:DIV_N-1][3];
  logic [EW-1:0]     ed_pp_r  [1:DIV_N-1][3];
  logic [DIST_W-1:0] ed_m_r   [1:DIV_N][3];
  logic [DIST_W-1:0] mg_r     [S_MG:S_DIVE];

  logic signed [CX-1:0] cx_r [0:CORDIC_N];
  logic signed [CX-1:0] cy_r [0:CORDIC_N];
  logic signed [CX-1:0] cz_r [0:CORDIC_N];

  logic signed [17:0]   cs_r, sn_r;
  logic signed [RW-1:0] rs_r [3];
  logic signed [RW-1:0] qpr_r [3];

  logic [NW-1:0]     dr_r  [S_NORM:S_DIVE][3];
  logic [NW-1:0]     dd_r  [S_NORM:S_DIVE][3];
  logic [DIV_N-1:0]  dq_r  [S_NORM:S_DIVE][3];
  logic              hit_r [S_NORM:S_DIVE][3];
  logic              zh_r  [S_NORM:S_DIVE][3];
  logic              sat_r [S_NORM:S_DIVE][3];

  logic [1:0]        o_st_r;
  logic [DIST_W-1:0] o_mg_r, o_dist_r;
  logic              o_hit_r;

  // prep inputs
  logic signed [W-1:0]  h_px [3];
  logic signed [W-1:0]  h_py [3];
  logic signed [CW-1:0] h_c  [3];
  logic signed [W:0]    h_sx [3];
  logic signed [W:0]    h_sy [3];
  logic [W:0]           h_ax [3];
  logic [W:0]           h_ay [3];
  logic [2*W+1:0]       h_qx [3];
  logic [2*W+1:0]       h_qy [3];
  logic [CW-1:0]        h_ac [3];
  logic [4*W-1:0]       h_c2 [3];
  logic [A-1:0]         h_ang;
  logic [31:0]          h_th, h_res;
  logic [1:0]           h_q;

  assign adv = !vld_r[S_OUT] || out_tready;
  assign pop = head_valid && adv;

  always_comb begin
    for (int e = 0; e < 3; e++) begin
      h_px[e] = head_data[e * W +: W];
      h_py[e] = head_data[(3 + e) * W +: W];
      h_c[e]  = head_data[6 * W + e * CW +: CW];
    end
    for (int e = 0; e < 3; e++) begin
      h_sx[e] = (W + 1)'(h_px[(e + 1) % 3]) - (W + 1)'(h_px[e]);
      h_sy[e] = (W + 1)'(h_py[(e + 1) % 3]) - (W + 1)'(h_py[e]);
      h_ax[e] = h_sx[e][W] ? -h_sx[e] : h_sx[e];
      h_ay[e] = h_sy[e][W] ? -h_sy[e] : h_sy[e];
      h_qx[e] = h_ax[e] * h_ax[e];
      h_qy[e] = h_ay[e] * h_ay[e];
      h_ac[e] = h_c[e][CW-1] ? -h_c[e] : h_c[e];
      h_c2[e] = h_ac[e][2*W-1:0] * h_ac[e][2*W-1:0];
    end
    h_ang = head_data[6 * W + 3 * CW + 2 +: A];
    h_th  = {h_ang, {(32 - A){1'b0}}};
    h_q   = 2'((h_th + 32'h2000_0000) >> 30);
    h_res = h_th - {h_q, 30'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= S_OUT; s++) begin
        vld_r[s] <= 1'b0;
      end
    end else if (adv) begin
      vld_r[0] <= head_valid;
      for (int s = 1; s <= S_OUT; s++) begin
        vld_r[s] <= vld_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g_px_r[0] <= h_px;
      g_py_r[0] <= h_py;
      g_sx_r[0] <= h_sx;
      g_sy_r[0] <= h_sy;
      g_c_r[0]  <= h_c;
      g_st_r[0] <= head_data[6 * W + 3 * CW +: 2];
      g_q_r[0]  <= h_q;
      for (int e = 0; e < 3; e++) begin
        ed_c2_r[0][e]  <= h_c2[e];
        ed_len_r[0][e] <= LNW'(h_qx[e]) + LNW'(h_qy[e]);
      end
      cx_r[0] <= $signed(CX'(CORDIC_GAIN));
      cy_r[0] <= '0;
      cz_r[0] <= CX'($signed(h_res));
      for (int s = 1; s <= S_ROUND; s++) begin
        g_px_r[s] <= g_px_r[s-1];
        g_py_r[s] <= g_py_r[s-1];
        g_sx_r[s] <= g_sx_r[s-1];
        g_sy_r[s] <= g_sy_r[s-1];
      end
      for (int s = 1; s <= S_PROD; s++) begin
        g_c_r[s] <= g_c_r[s-1];
      end
      for (int s = 1; s <= S_DIVE; s++) begin
        g_st_r[s] <= g_st_r[s-1];
      end
      for (int s = 1; s <= CORDIC_N; s++) begin
        g_q_r[s] <= g_q_r[s-1];
      end
      for (int s = 1; s < DIV_N; s++) begin
        ed_c2_r[s]  <= ed_c2_r[s-1];
        ed_len_r[s] <= ed_len_r[s-1];
      end
    end
  end

  for (genvar k = 1; k <= DIV_N; k++) begin : g_ed
    for (genvar e = 0; e < 3; e++) begin : g_lane
      logic [EW-1:0]     mm_in, pp_in, cand, len_w;
      logic [DIST_W-1:0] m_in;
      logic              ok;
      if (k == 1) begin : g_first
        assign mm_in = '0;
        assign pp_in = '0;
        assign m_in  = '0;
      end else begin : g_next
        assign mm_in = ed_mm_r[k-1][e];
        assign pp_in = ed_pp_r[k-1][e];
        assign m_in  = ed_m_r[k-1][e];
      end
      assign len_w = EW'(ed_len_r[k-1][e]);
      assign cand  = mm_in + (pp_in << (DIV_N - k + 1)) + (len_w << (2 * (DIV_N - k)));
      assign ok    = (cand <= EW'(ed_c2_r[k-1][e]));
      always_ff @(posedge clk) begin
        if (adv) begin
          ed_m_r[k][e] <= ok ? (m_in | (DIST_W'(1) << (DIV_N - k))) : m_in;
        end
      end
      if (k < DIV_N) begin : g_acc
        always_ff @(posedge clk) begin
          if (adv) begin
            ed_mm_r[k][e] <= ok ? cand : mm_in;
            ed_pp_r[k][e] <= ok ? pp_in + (len_w << (DIV_N - k)) : pp_in;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mg_r[S_MG] <= (ed_m_r[DIV_N][0] < ed_m_r[DIV_N][1]) ?
                    ((ed_m_r[DIV_N][0] < ed_m_r[DIV_N][2]) ? ed_m_r[DIV_N][0]
                                                           : ed_m_r[DIV_N][2]) :
                    ((ed_m_r[DIV_N][1] < ed_m_r[DIV_N][2]) ? ed_m_r[DIV_N][1]
                                                           : ed_m_r[DIV_N][2]);
      for (int s = S_MG + 1; s <= S_DIVE; s++) begin
        mg_r[s] <= mg_r[s-1];
      end
    end
  end

  for (genvar i = 1; i <= CORDIC_N; i++) begin : g_cord
    logic signed [CX-1:0] dx, dy, at;
    assign dx = cy_r[i-1] >>> (i - 1);
    assign dy = cx_r[i-1] >>> (i - 1);
    assign at = $signed(CX'(ATAN_TURN[i-1]));
    always_ff @(posedge clk) begin
      if (adv) begin
        if (!cz_r[i-1][CX-1]) begin
          cx_r[i] <= cx_r[i-1] - dx;
          cy_r[i] <= cy_r[i-1] + dy;
          cz_r[i] <= cz_r[i-1] - at;
        end else begin
          cx_r[i] <= cx_r[i-1] + dx;
          cy_r[i] <= cy_r[i-1] - dy;
          cz_r[i] <= cz_r[i-1] + at;
        end
      end
    end
  end

  function automatic logic signed [17:0] clamp_unit(input logic signed [CX-1:0] v);
    logic signed [CX-1:0] r;
    r = (v + RHALF) >>> 14;
    if (r > UNIT) begin
      r = UNIT;
    end else if (r < NUNIT) begin
      r = NUNIT;
    end
    return r[17:0];
  endfunction

  logic signed [17:0] rc, rsn;
  assign rc  = clamp_unit(cx_r[CORDIC_N]);
  assign rsn = clamp_unit(cy_r[CORDIC_N]);

  always_ff @(posedge clk) begin
    if (adv) begin
      unique case (g_q_r[CORDIC_N])
        2'd0: begin
          cs_r <= rc;
          sn_r <= rsn;
        end
        2'd1: begin
          cs_r <= -rsn;
          sn_r <= rc;
        end
        2'd2: begin
          cs_r <= -rc;
          sn_r <= -rsn;
        end
        default: begin
          cs_r <= rsn;
          sn_r <= -rc;
        end
      endcase
    end
  end

  for (genvar e = 0; e < 3; e++) begin : g_ray
    logic signed [RW-1:0] t1, t2, t3, t4;
    logic signed [NW-1:0] rsn_w, qprn, qpsn, rsa, qpra, qpsa;
    logic                 neg, par, cond;
    assign t1 = cs_r * g_sy_r[S_ROUND][e];
    assign t2 = sn_r * g_sx_r[S_ROUND][e];
    assign t3 = g_px_r[S_ROUND][e] * sn_r;
    assign t4 = g_py_r[S_ROUND][e] * cs_r;
    always_ff @(posedge clk) begin
      if (adv) begin
        rs_r[e]  <= t1 - t2;
        qpr_r[e] <= t3 - t4;
      end
    end

    assign rsn_w = NW'(rs_r[e]);
    assign qprn  = NW'(qpr_r[e]);
    assign qpsn  = NW'(g_c_r[S_PROD][e]);
    assign neg   = rs_r[e] < 0;
    assign rsa   = neg ? -rsn_w : rsn_w;
    assign qpra  = neg ? -qprn : qprn;
    assign qpsa  = neg ? -qpsn : qpsn;
    assign par   = (rs_r[e] == '0);
    assign cond  = !par && qpra >= 0 && qpra <= rsa && qpsa >= 0;

    always_ff @(posedge clk) begin
      if (adv) begin
        zh_r[S_NORM][e]  <= par && (qpr_r[e] == '0);
        hit_r[S_NORM][e] <= (par && (qpr_r[e] == '0)) || cond;
        sat_r[S_NORM][e] <= qpsa >= rsa;
        dr_r[S_NORM][e]  <= qpsa;
        dd_r[S_NORM][e]  <= rsa;
        dq_r[S_NORM][e]  <= '0;
      end
    end

    for (genvar s = S_NORM + 1; s <= S_DIVE; s++) begin : g_div
      logic [NW:0] r2;
      logic        ge;
      assign r2 = {dr_r[s-1][e], 1'b0};
      assign ge = r2 >= {1'b0, dd_r[s-1][e]};
      always_ff @(posedge clk) begin
        if (adv) begin
          dr_r[s][e]  <= ge ? NW'(r2 - {1'b0, dd_r[s-1][e]}) : NW'(r2);
          dd_r[s][e]  <= dd_r[s-1][e];
          dq_r[s][e]  <= {dq_r[s-1][e][DIV_N-2:0], ge};
          zh_r[s][e]  <= zh_r[s-1][e];
          hit_r[s][e] <= hit_r[s-1][e];
          sat_r[s][e] <= sat_r[s-1][e];
        end
      end
    end
  end

  function automatic logic [DIST_W-1:0] lane_dist(input logic zh, input logic sat,
                                                  input logic [DIV_N-1:0] q);
    logic [DIST_W-1:0] r;
    r = zh ? '0 : (sat ? DIST_SAT : q);
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (adv) begin
      o_st_r <= g_st_r[S_DIVE];
      if (stat_t'(g_st_r[S_DIVE]) != ST_INSIDE) begin
        o_mg_r   <= '0;
        o_hit_r  <= 1'b0;
        o_dist_r <= '0;
      end else begin
        o_mg_r <= mg_r[S_DIVE];
        priority if (hit_r[S_DIVE][0]) begin
          o_hit_r  <= 1'b1;
          o_dist_r <= lane_dist(zh_r[S_DIVE][0], sat_r[S_DIVE][0], dq_r[S_DIVE][0]);
        end else if (hit_r[S_DIVE][1]) begin
          o_hit_r  <= 1'b1;
          o_dist_r <= lane_dist(zh_r[S_DIVE][1], sat_r[S_DIVE][1], dq_r[S_DIVE][1]);
        end else if (hit_r[S_DIVE][2]) begin
          o_hit_r  <= 1'b1;
          o_dist_r <= lane_dist(zh_r[S_DIVE][2], sat_r[S_DIVE][2], dq_r[S_DIVE][2]);
        end else begin
          o_hit_r  <= 1'b0;
          o_dist_r <= '0;
        end
      end
    end
  end

  assign out_tvalid = vld_r[S_OUT];
  assign out_tdata  = {o_dist_r, o_mg_r};
  assign out_tuser  = {o_hit_r, o_st_r};

endmodule
